// ===== hw/rtl/brds_pkg.sv =====
// ----------------------------------------------------------------------------
// brds_pkg
// Shared types and constants of the button repeat and duration setter.
// ----------------------------------------------------------------------------
package brds_pkg;

  localparam int NUM_BUTTONS = 3;

  localparam int BTN_MODE  = 0;
  localparam int BTN_RAISE = 1;
  localparam int BTN_STORE = 2;

  localparam logic [7:0] INTERVAL_RESET = 8'd50;
  localparam logic [7:0] PEND_MAX       = 8'd255;
  localparam logic [6:0] EDIT_MIN       = 7'd1;
  localparam logic [6:0] EDIT_MAX       = 7'd99;
  localparam logic [6:0] RED_RESET      = 7'd5;
  localparam logic [6:0] YELLOW_RESET   = 7'd2;
  localparam logic [6:0] GREEN_RESET    = 7'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RED    = 2'd1,
    MODE_YELLOW = 2'd2,
    MODE_GREEN  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0] pressed_bits;
    logic [2:0] held_long_bits;
  } item_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic [6:0] edit_value_now;
    logic [6:0] red_time;
    logic [6:0] yellow_time;
    logic [6:0] green_time;
    logic       restart_red;
  } result_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] add_press;
  } btn_event_t;

endpackage

// ===== hw/rtl/brds_fifo.sv =====
// ----------------------------------------------------------------------------
// brds_fifo
// Small synchronous queue with registered storage and count-based flags.
// ----------------------------------------------------------------------------
module brds_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/brds_front.sv =====
// ----------------------------------------------------------------------------
// brds_front
// Per-button phase machines and auto-repeat counters; emits press events.
// ----------------------------------------------------------------------------
module brds_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [7:0]            cfg_data,
  input  logic                  push,
  input  brds_pkg::item_t       item,
  input  logic                  evt_full,
  output logic                  evt_push,
  output brds_pkg::btn_event_t  evt_data
);

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  phase_t     phase      [brds_pkg::NUM_BUTTONS];
  phase_t     phase_next [brds_pkg::NUM_BUTTONS];
  logic [7:0] rpt        [brds_pkg::NUM_BUTTONS];
  logic [7:0] rpt_next   [brds_pkg::NUM_BUTTONS];
  logic [7:0] repeat_interval;
  logic       go;

  assign go       = push && !evt_full;
  assign evt_push = go;

  always_comb begin
    evt_data = '0;
    for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
      phase_next[i] = phase[i];
      rpt_next[i]   = rpt[i];
      unique case (phase[i])
        PH_PRESSED: begin
          if (!item.pressed_bits[i]) begin
            phase_next[i] = PH_RELEASED;
          end else if (item.held_long_bits[i]) begin
            phase_next[i] = PH_LONG;
          end
        end
        PH_LONG: begin
          if (!item.pressed_bits[i]) begin
            phase_next[i] = PH_RELEASED;
            rpt_next[i]   = '0;
          end else if (rpt[i] >= repeat_interval) begin
            evt_data.add_press[i] = 1'b1;
            rpt_next[i]           = '0;
          end else begin
            rpt_next[i] = rpt[i] + 8'd1;
          end
        end
        default: begin
          phase_next[i] = PH_RELEASED;
          if (item.pressed_bits[i]) begin
            phase_next[i]         = PH_PRESSED;
            evt_data.add_press[i] = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= brds_pkg::INTERVAL_RESET;
    end else if (cfg_wr) begin
      repeat_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
        phase[i] <= PH_RELEASED;
        rpt[i]   <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
        phase[i] <= phase_next[i];
        rpt[i]   <= rpt_next[i];
      end
    end
  end

endmodule

// ===== hw/rtl/brds_back.sv =====
// ----------------------------------------------------------------------------
// brds_back
// Pending press counters and the settings mode machine; builds each result.
// ----------------------------------------------------------------------------
module brds_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_empty,
  input  brds_pkg::btn_event_t evt_data,
  output logic                 evt_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output brds_pkg::result_t    res_data
);

  brds_pkg::mode_t mode;
  brds_pkg::mode_t mode_next;
  logic [7:0] pend      [brds_pkg::NUM_BUTTONS];
  logic [7:0] pend_mid  [brds_pkg::NUM_BUTTONS];
  logic [7:0] pend_next [brds_pkg::NUM_BUTTONS];
  logic [6:0] edit;
  logic [6:0] edit_next;
  logic [6:0] edit_inc;
  logic [6:0] red;
  logic [6:0] red_next;
  logic [6:0] yellow;
  logic [6:0] yellow_next;
  logic [6:0] green;
  logic [6:0] green_next;
  logic       restart;
  logic       go;

  assign go       = !evt_empty && !res_full;
  assign evt_pop  = go;
  assign res_push = go;

  always_comb begin
    for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
      pend_mid[i] = pend[i];
      if (evt_data.add_press[i] && pend[i] != brds_pkg::PEND_MAX) begin
        pend_mid[i] = pend[i] + 8'd1;
      end
      pend_next[i] = pend_mid[i];
    end
    mode_next   = mode;
    edit_next   = edit;
    edit_inc    = '0;
    red_next    = red;
    yellow_next = yellow;
    green_next  = green;
    restart     = 1'b0;

    if (mode == brds_pkg::MODE_NORMAL) begin
      if (pend_mid[brds_pkg::BTN_MODE] != '0) begin
        pend_next[brds_pkg::BTN_MODE] = pend_mid[brds_pkg::BTN_MODE] - 8'd1;
        mode_next = brds_pkg::MODE_RED;
        edit_next = brds_pkg::EDIT_MIN;
      end
    end else begin
      if (pend_mid[brds_pkg::BTN_MODE] != '0) begin
        pend_next[brds_pkg::BTN_MODE] = pend_mid[brds_pkg::BTN_MODE] - 8'd1;
        mode_next = brds_pkg::mode_t'(2'(mode + 2'd1));
        edit_next = brds_pkg::EDIT_MIN;
        restart   = (mode == brds_pkg::MODE_GREEN);
      end
      if (pend_mid[brds_pkg::BTN_RAISE] != '0) begin
        pend_next[brds_pkg::BTN_RAISE] = pend_mid[brds_pkg::BTN_RAISE] - 8'd1;
        edit_inc  = edit_next + 7'd1;
        edit_next = (edit_inc > brds_pkg::EDIT_MAX) ? brds_pkg::EDIT_MIN : edit_inc;
      end
      if (pend_mid[brds_pkg::BTN_STORE] != '0) begin
        pend_next[brds_pkg::BTN_STORE] = pend_mid[brds_pkg::BTN_STORE] - 8'd1;
        unique case (mode)
          brds_pkg::MODE_RED:    red_next    = edit_next;
          brds_pkg::MODE_YELLOW: yellow_next = edit_next;
          default:               green_next  = edit_next;
        endcase
      end
    end

    res_data.mode_now       = mode_next;
    res_data.edit_value_now = edit_next;
    res_data.red_time       = red_next;
    res_data.yellow_time    = yellow_next;
    res_data.green_time     = green_next;
    res_data.restart_red    = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
        pend[i] <= '0;
      end
      mode   <= brds_pkg::MODE_NORMAL;
      edit   <= brds_pkg::EDIT_MIN;
      red    <= brds_pkg::RED_RESET;
      yellow <= brds_pkg::YELLOW_RESET;
      green  <= brds_pkg::GREEN_RESET;
    end else if (go) begin
      for (int i = 0; i < brds_pkg::NUM_BUTTONS; i++) begin
        pend[i] <= pend_next[i];
      end
      mode   <= mode_next;
      edit   <= edit_next;
      red    <= red_next;
      yellow <= yellow_next;
      green  <= green_next;
    end
  end

endmodule

// ===== hw/rtl/button_repeat_duration_setter_unit.sv =====
// ----------------------------------------------------------------------------
// button_repeat_duration_setter_unit
// Button auto-repeat front end feeding a traffic light duration setter.
//
//   channel  direction  handshake          payload
//   tick     in         push / full        item   (brds_pkg::item_t)
//   result   out        pop / empty        result (brds_pkg::result_t)
//   config   in         cfg_wr             cfg_data (repeat interval)
//
// One tick accepted per cycle while full is low; its result crosses the
// event and result queues. The front stage updates button phases on accept;
// the back stage updates pending counts and the mode machine as it moves an
// event into the result queue. A full result queue stalls the back stage
// and, once the event queue fills, raises full. Reset is synchronous.
// ----------------------------------------------------------------------------
module button_repeat_duration_setter_unit #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  input  brds_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output brds_pkg::result_t result,
  output logic              empty
);

  logic                 evt_push;
  logic                 evt_full;
  logic                 evt_pop;
  logic                 evt_empty;
  brds_pkg::btn_event_t evt_in;
  brds_pkg::btn_event_t evt_out;
  logic                 res_push;
  logic                 res_full;
  brds_pkg::result_t    res_in;

  assign full = evt_full;

  brds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .evt_full (evt_full),
    .evt_push (evt_push),
    .evt_data (evt_in)
  );

  brds_fifo #(
    .WIDTH ($bits(brds_pkg::btn_event_t)),
    .DEPTH (MID_DEPTH)
  ) u_evt_q (
    .clk   (clk),
    .rst   (rst),
    .push  (evt_push),
    .wdata (evt_in),
    .full  (evt_full),
    .pop   (evt_pop),
    .rdata (evt_out),
    .empty (evt_empty)
  );

  brds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_empty (evt_empty),
    .evt_data  (evt_out),
    .evt_pop   (evt_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  brds_fifo #(
    .WIDTH ($bits(brds_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_restart_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.restart_red) |-> (result.mode_now == brds_pkg::MODE_NORMAL))
    else $error("restart transaction without return to normal mode");

  a_edit_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.edit_value_now >= brds_pkg::EDIT_MIN &&
                result.edit_value_now <= brds_pkg::EDIT_MAX))
    else $error("edit value out of range");

  a_evt_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !evt_empty)
    else $error("accepted transaction lost before the back stage");
`endif

endmodule

// ===== verif/brds_setting_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brds_setting_check
// Watches the tick, result and config channels of the button repeat and
// duration setter. On every accepted tick it advances its own copy of the
// button phases, pending presses, repeat counters and settings machine, and
// queues the setting the block must return. Every accepted result is checked
// field by field against the oldest queued setting.
// ----------------------------------------------------------------------------
module brds_setting_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  input  logic              full,
  input  brds_pkg::item_t   item,
  input  logic              pop,
  input  logic              empty,
  input  brds_pkg::result_t result,
  output int                failures,
  output int                outstanding
);

  typedef enum logic [1:0] {
    BP_RELEASED = 2'd0,
    BP_PRESSED  = 2'd1,
    BP_LONG     = 2'd2
  } btn_phase_t;

  btn_phase_t        phase_of  [brds_pkg::NUM_BUTTONS];
  logic [7:0]        pend_of   [brds_pkg::NUM_BUTTONS];
  logic [7:0]        repeat_of [brds_pkg::NUM_BUTTONS];
  logic [7:0]        interval_now;
  brds_pkg::mode_t   mode_cur;
  logic [6:0]        edit_cur;
  logic [6:0]        red_cur;
  logic [6:0]        yellow_cur;
  logic [6:0]        green_cur;
  brds_pkg::result_t setting_q [$];

  task automatic report(input string what);
    failures++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void add_pending(input int b);
    if (pend_of[b] != brds_pkg::PEND_MAX) pend_of[b]++;
  endfunction

  function automatic logic use_pending(input int b);
    if (pend_of[b] != 8'd0) begin
      pend_of[b]--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic brds_pkg::result_t advance_settings(input brds_pkg::item_t it);
    brds_pkg::result_t r;
    brds_pkg::mode_t   m;
    logic              restart;
    logic              down;
    logic              held;
    int                b;
    restart = 1'b0;
    for (b = 0; b < brds_pkg::NUM_BUTTONS; b++) begin
      down = it.pressed_bits[b];
      held = it.held_long_bits[b];
      case (phase_of[b])
        BP_PRESSED: begin
          if (!down) phase_of[b] = BP_RELEASED;
          else if (held) phase_of[b] = BP_LONG;
        end
        BP_LONG: begin
          if (!down) begin
            phase_of[b]  = BP_RELEASED;
            repeat_of[b] = 8'd0;
          end else if (repeat_of[b] >= interval_now) begin
            add_pending(b);
            repeat_of[b] = 8'd0;
          end else begin
            repeat_of[b]++;
          end
        end
        default: begin
          phase_of[b] = BP_RELEASED;
          if (down) begin
            phase_of[b] = BP_PRESSED;
            add_pending(b);
          end
        end
      endcase
    end

    m = mode_cur;
    if (m == brds_pkg::MODE_NORMAL) begin
      if (use_pending(brds_pkg::BTN_MODE)) begin
        mode_cur = brds_pkg::MODE_RED;
        edit_cur = brds_pkg::EDIT_MIN;
      end
    end else begin
      if (use_pending(brds_pkg::BTN_MODE)) begin
        mode_cur = brds_pkg::mode_t'(m + 2'd1);
        edit_cur = brds_pkg::EDIT_MIN;
        restart  = (m == brds_pkg::MODE_GREEN);
      end
      if (use_pending(brds_pkg::BTN_RAISE)) begin
        edit_cur = (edit_cur >= brds_pkg::EDIT_MAX) ? brds_pkg::EDIT_MIN : edit_cur + 7'd1;
      end
      if (use_pending(brds_pkg::BTN_STORE)) begin
        case (m)
          brds_pkg::MODE_RED:    red_cur    = edit_cur;
          brds_pkg::MODE_YELLOW: yellow_cur = edit_cur;
          default:               green_cur  = edit_cur;
        endcase
      end
    end

    r.mode_now       = mode_cur;
    r.edit_value_now = edit_cur;
    r.red_time       = red_cur;
    r.yellow_time    = yellow_cur;
    r.green_time     = green_cur;
    r.restart_red    = restart;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    brds_pkg::result_t want;
    int                b;
    if (rst) begin
      for (b = 0; b < brds_pkg::NUM_BUTTONS; b++) begin
        phase_of[b]  = BP_RELEASED;
        pend_of[b]   = 8'd0;
        repeat_of[b] = 8'd0;
      end
      failures     = 0;
      interval_now = brds_pkg::INTERVAL_RESET;
      mode_cur     = brds_pkg::MODE_NORMAL;
      edit_cur     = brds_pkg::EDIT_MIN;
      red_cur      = brds_pkg::RED_RESET;
      yellow_cur   = brds_pkg::YELLOW_RESET;
      green_cur    = brds_pkg::GREEN_RESET;
      setting_q.delete();
    end else begin
      if (cfg_wr) interval_now = cfg_data;
      if (pop && !empty) begin
        if (setting_q.size() == 0) begin
          report("result transaction with no tick waiting");
        end else begin
          want = setting_q.pop_front();
          if (result.mode_now !== want.mode_now)
            report($sformatf("mode_now %0d, expected %0d", result.mode_now, want.mode_now));
          if (result.edit_value_now !== want.edit_value_now)
            report($sformatf("edit_value_now %0d, expected %0d",
                             result.edit_value_now, want.edit_value_now));
          if (result.red_time !== want.red_time)
            report($sformatf("red_time %0d, expected %0d", result.red_time, want.red_time));
          if (result.yellow_time !== want.yellow_time)
            report($sformatf("yellow_time %0d, expected %0d",
                             result.yellow_time, want.yellow_time));
          if (result.green_time !== want.green_time)
            report($sformatf("green_time %0d, expected %0d",
                             result.green_time, want.green_time));
          if (result.restart_red !== want.restart_red)
            report($sformatf("restart_red %0b, expected %0b",
                             result.restart_red, want.restart_red));
        end
      end
      if (push && !full) setting_q.push_back(advance_settings(item));
    end
    outstanding <= setting_q.size();
  end

endmodule

// ===== verif/button_repeat_duration_setter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_repeat_duration_setter_unit_test
// Drives ticks of button flags into the duration setter and drains its
// results with random gaps on both sides. A short opening sequence walks all
// four modes, same-tick presses, stray held flags and release from long
// hold; a saturation run fills the pending counts; random press and hold
// patterns then run under several repeat intervals. Checking is done by
// brds_setting_check.
// ----------------------------------------------------------------------------
module button_repeat_duration_setter_unit_test;

  localparam int QUIET_LIMIT = 400;
  localparam int PHASES      = 6;
  localparam int PHASE_TICKS = 190;

  logic              clk;
  logic              rst      = 1'b1;
  logic              cfg_wr   = 1'b0;
  logic [7:0]        cfg_data = 8'd0;
  logic              push     = 1'b0;
  brds_pkg::item_t   item     = '0;
  logic              full;
  logic              pop      = 1'b0;
  brds_pkg::result_t result;
  logic              empty;
  int                failures;
  int                outstanding;

  logic       push_calm = 1'b0;
  logic       pop_calm  = 1'b0;
  int         pop_wait;
  int         pops_done = 0;
  int         quiet     = 0;

  int hold_left [brds_pkg::NUM_BUTTONS];
  int up_left   [brds_pkg::NUM_BUTTONS];
  int down_for  [brds_pkg::NUM_BUTTONS];
  int long_at   [brds_pkg::NUM_BUTTONS];

  button_repeat_duration_setter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .pop      (pop),
    .result   (result),
    .empty    (empty)
  );

  brds_setting_check setting_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .item        (item),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_run(input logic [2:0] pressed, input logic [2:0] held, input int n);
    int k;
    int gap;
    for (k = 0; k < n; k++) begin
      gap = push_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push                <= 1'b1;
      item.pressed_bits   <= pressed;
      item.held_long_bits <= held;
      @(posedge clk);
      while (full) @(posedge clk);
    end
  endtask

  task automatic set_interval(input logic [7:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr <= 1'b0;
  endtask

  // press and hold patterns per button, with a little noise mixed in
  function automatic brds_pkg::item_t next_tick(input int long_pct);
    brds_pkg::item_t it;
    int              b;
    int              roll;
    int              pct;
    it = '0;
    if ($urandom_range(0, 99) < 8) begin
      it.pressed_bits   = 3'($urandom_range(0, 7));
      it.held_long_bits = 3'($urandom_range(0, 7));
      return it;
    end
    for (b = 0; b < brds_pkg::NUM_BUTTONS; b++) begin
      if (hold_left[b] > 0) begin
        hold_left[b]--;
        down_for[b]++;
        it.pressed_bits[b]   = 1'b1;
        it.held_long_bits[b] = (down_for[b] >= long_at[b]);
      end else if (up_left[b] > 0) begin
        up_left[b]--;
      end else begin
        pct  = (b == brds_pkg::BTN_MODE) ? long_pct / 3 : long_pct;
        roll = $urandom_range(0, 99);
        if (roll < pct) hold_left[b] = $urandom_range(20, 300);
        else if (roll < pct + 25) hold_left[b] = $urandom_range(5, 20);
        else hold_left[b] = $urandom_range(1, 4);
        hold_left[b]--;
        long_at[b]           = $urandom_range(2, 10);
        down_for[b]          = 1;
        up_left[b]           = $urandom_range(1, 8);
        it.pressed_bits[b]   = 1'b1;
      end
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_wait  = $urandom_range(0, 6);
    end else if (pop && !empty) begin
      pops_done++;
      if (pops_done % 120 == 0) pop_calm = ($urandom_range(0, 2) == 0);
      pop_wait = pop_calm ? 0 : $urandom_range(0, 6);
      pop <= (pop_wait == 0);
    end else if (!pop) begin
      if (pop_wait > 0) pop_wait--;
      if (pop_wait == 0) pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** button_repeat_duration_setter_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0]      intervals [PHASES];
    int              long_pcts [PHASES];
    brds_pkg::item_t t;
    int              ph;
    int              i;
    int              b;

    intervals = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, brds_pkg::INTERVAL_RESET};
    long_pcts = '{10, 40, 10, 10, 15, 20};
    intervals[3] = 8'($urandom_range(2, 254));
    for (b = 0; b < brds_pkg::NUM_BUTTONS; b++) begin
      hold_left[b] = 0;
      up_left[b]   = 0;
      down_for[b]  = 0;
      long_at[b]   = 0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // walk all modes at the reset interval, ending back in normal mode
    send_run(3'd0, 3'd0, 1);
    send_run(3'd7, 3'd7, 1);
    send_run(3'd0, 3'd7, 1);
    send_run(3'd2, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd4, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd7, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd1, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd5, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd1, 3'd0, 1);
    send_run(3'd1, 3'd1, 2);
    send_run(3'd0, 3'd1, 1);
    send_run(3'd1, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd1, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);
    send_run(3'd1, 3'd0, 1);
    send_run(3'd0, 3'd0, 1);

    for (ph = 0; ph < PHASES; ph++) begin
      set_interval(intervals[ph]);
      push_calm = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        // fill raise and store pending counts while in normal mode
        send_run(3'd6, 3'd0, 1);
        send_run(3'd6, 3'd6, 279);
        for (b = 0; b < brds_pkg::NUM_BUTTONS; b++) up_left[b] = 2;
      end
      for (i = 0; i < PHASE_TICKS; i++) begin
        if (i == PHASE_TICKS / 2) push_calm = ($urandom_range(0, 3) == 0);
        t = next_tick(long_pcts[ph]);
        send_run(t.pressed_bits, t.held_long_bits, 1);
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("** button_repeat_duration_setter_unit: PASSED **");
    end else begin
      $display("** button_repeat_duration_setter_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/brds_pkg.sv
hw/rtl/brds_fifo.sv
hw/rtl/brds_front.sv
hw/rtl/brds_back.sv
hw/rtl/button_repeat_duration_setter_unit.sv
verif/brds_setting_check.sv
verif/button_repeat_duration_setter_unit_test.sv
